### hw/rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// Block bitmap allocator package
// Shared constants, codes and types for the free-block bitmap allocator.
// ---------------------------------------------------------------------------
package bba_pkg;

   // Disk geometry.
   localparam int BLOCK_BYTES     = 512;
   localparam int MAX_BLOCKS      = 65536;
   localparam int BITS_PER_BLOCK  = BLOCK_BYTES * 8;
   localparam int BLK_SHIFT       = $clog2(BITS_PER_BLOCK);

   // Bitmap memory organization: one 64-bit word per row.
   localparam int WORD_BITS       = 64;
   localparam int BIT_W           = $clog2(WORD_BITS);
   localparam int MAP_WORDS       = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W         = $clog2(MAP_WORDS);
   localparam int SPAN_W          = WADDR_W + 1;
   localparam int WORDS_PER_BLOCK = BITS_PER_BLOCK / WORD_BITS;
   localparam int MAX_NB          = (MAX_BLOCKS + BITS_PER_BLOCK - 1) / BITS_PER_BLOCK;
   localparam int NB_W            = $clog2(MAX_NB + 1);
   localparam int POP_W           = $clog2(WORD_BITS + 1);

   // Field widths.
   localparam int FUNC_W   = 2;
   localparam int BLOCK_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 17;
   localparam int TOTAL_W  = 17;

   localparam logic [TOTAL_W-1:0] MAX_TOTAL   = TOTAL_W'(MAX_BLOCKS);
   localparam logic [TOTAL_W-1:0] RESET_TOTAL = TOTAL_W'(65536);
   localparam logic [TOTAL_W-1:0] MIN_TOTAL   = TOTAL_W'(4);
   localparam logic [TOTAL_W-1:0] RESERVED    = TOTAL_W'(3);

   // Configuration port.
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;
   localparam logic [CSR_AW-1:0] CSR_TOTAL_ADDR = CSR_AW'(0);

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = FUNC_W'(0);
   localparam logic [FUNC_W-1:0] FUNC_FREE   = FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FUNC_COUNT  = FUNC_W'(2);
   localparam logic [FUNC_W-1:0] FUNC_FORMAT = FUNC_W'(3);

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_FULL      = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_TOO_SMALL = STATUS_W'(2);

   // Disk geometry derived from the configured block count.
   typedef struct packed {
      logic [TOTAL_W-1:0] eff_total;
      logic [SPAN_W-1:0]  span_words;
      logic [TOTAL_W-1:0] fmt_lo;
      logic               too_small;
   } bba_geom_type;

   // Results of the shared word unit.
   typedef struct packed {
      logic [POP_W-1:0]     pop;
      logic                 hit;
      logic [BIT_W-1:0]     first;
      logic [WORD_BITS-1:0] fmt_mask;
   } bba_word_res_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_COUNT,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_FORMAT,
      ST_DONE
   } bba_state_type;

endpackage

### hw/rtl/bba_if.sv
// ---------------------------------------------------------------------------
// Block bitmap allocator channels
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface bba_req_if;
   import bba_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [BLOCK_W-1:0]  block_number;

   modport source (output valid, output func, output block_number, input ready);
   modport sink   (input valid, input func, input block_number, output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BLOCK_W-1:0]  allocated_block;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, output status, output allocated_block,
                   output free_count, input ready);
   modport sink   (input valid, input status, input allocated_block,
                   input free_count, output ready);
endinterface

### hw/rtl/block_bitmap_allocator_unit.sv
// ---------------------------------------------------------------------------
// Block bitmap allocator
// First-fit free-block allocator over a bitmap of up to 65536 disk blocks.
// ---------------------------------------------------------------------------
// The bitmap lives in one single-port memory of 1024 words of 64 bits, and
// allocate, count and format walk it one word per cycle through a shared word
// unit (population count, lowest-set-bit search and format mask). After reset
// the block clears the memory and takes no request beat in that time;
// configuration writes are taken throughout. One request is worked on at a
// time. An allocate reads up to span words, where span is 64 words per
// bitmap block in use (at most 1024 words), and stops early at the first
// word holding a free block. A count always reads all span words, a free
// reads and rewrites at most one word and a format rewrites the whole map.
// The result then moves into the response register once that register is
// free, after which the next request beat is taken even if the response
// beat is still waiting.
module block_bitmap_allocator_unit (
   input  logic                       clock,
   input  logic                       reset,
   bba_req_if.sink                    req_chan,
   bba_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bba_pkg::CSR_AW-1:0] paddr,
   input  logic [bba_pkg::CSR_DW-1:0] pwdata,
   output logic [bba_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import bba_pkg::*;

   // Geometry derived from the disk size register: the clamped block count,
   // the number of bitmap words in use, the first block a format frees and
   // whether the disk is too small to format at all.
   bba_geom_type geom;

   // The register file holds the disk size; the user must write it only while the
   // engine is idle, so geometry is steady during any operation (not enforced).
   bba_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .geom    (geom)
   );

   // The engine owns the bitmap memory, the sequencer and the response
   // register that decouples the two channels.
   bba_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .geom     (geom),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

### hw/rtl/bba_csr.sv
// ---------------------------------------------------------------------------
// Block bitmap allocator register file
// Holds the disk size and derives the disk geometry the engine works with.
// ---------------------------------------------------------------------------
module bba_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [bba_pkg::CSR_AW-1:0] paddr,
   input  logic [bba_pkg::CSR_DW-1:0] pwdata,
   output logic [bba_pkg::CSR_DW-1:0] prdata,
   output logic                    pready,
   output bba_pkg::bba_geom_type   geom
);
   import bba_pkg::*;

   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [TOTAL_W-1:0] eff;
   logic [TOTAL_W:0]   round_up;
   logic [NB_W-1:0]    nb;
   logic [31:0]        span_full;

   always_comb begin
      total_in = total_ff;
      if (psel && penable && pwrite && paddr == CSR_TOTAL_ADDR) begin
         total_in = pwdata[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= RESET_TOTAL;
      end else begin
         total_ff <= total_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_TOTAL_ADDR) ? CSR_DW'(total_ff) : '0;

   // Geometry: clamp to the map size, then the number of bitmap blocks in use.
   always_comb begin
      eff       = (total_ff > MAX_TOTAL) ? MAX_TOTAL : total_ff;
      round_up  = {1'b0, eff} + (TOTAL_W + 1)'(BITS_PER_BLOCK - 1);
      nb        = NB_W'(round_up >> BLK_SHIFT);
      span_full = 32'(nb) * 32'(WORDS_PER_BLOCK);
      if (span_full > 32'(MAP_WORDS)) begin
         span_full = 32'(MAP_WORDS);
      end
      geom.eff_total  = eff;
      geom.span_words = SPAN_W'(span_full);
      geom.fmt_lo     = TOTAL_W'(nb) + RESERVED;
      geom.too_small  = (eff <= MIN_TOTAL) || (eff <= TOTAL_W'(nb) + RESERVED);
   end

endmodule

### hw/rtl/bba_word_unit.sv
// ---------------------------------------------------------------------------
// Block bitmap allocator word unit
// Shared per-word logic: population count, lowest free bit, format mask.
// ---------------------------------------------------------------------------
module bba_word_unit (
   input  logic [bba_pkg::WORD_BITS-1:0] scan_word,
   input  logic [bba_pkg::WADDR_W-1:0]   scan_addr,
   input  logic [bba_pkg::WADDR_W-1:0]   fmt_addr,
   input  bba_pkg::bba_geom_type         geom,
   output bba_pkg::bba_word_res_type     res
);
   import bba_pkg::*;

   localparam int BYTES = WORD_BITS / 8;
   localparam int BYTE_W = $clog2(BYTES);

   logic [WORD_BITS-1:0] search_word;
   logic [7:0]           sel_byte;
   logic [BYTE_W-1:0]    byte_idx;
   logic [2:0]           bit_idx;
   logic                 byte_hit;
   logic [POP_W-1:0]     pop_sum;
   logic [TOTAL_W-1:0]   addr_ext;
   logic [TOTAL_W-1:0]   lo_word;
   logic [TOTAL_W-1:0]   hi_word;
   logic [WORD_BITS-1:0] low_mask;
   logic [WORD_BITS-1:0] high_mask;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + 4'(v[i]);
      end
      return c;
   endfunction

   // Block zero is never granted, so its bit is hidden from the search.
   always_comb begin
      search_word = scan_word;
      if (scan_addr == '0) begin
         search_word[0] = 1'b0;
      end
   end

   // Population count, one byte at a time.
   always_comb begin
      pop_sum = '0;
      for (int b = 0; b < BYTES; b++) begin
         pop_sum = pop_sum + POP_W'(pop8(scan_word[b*8 +: 8]));
      end
   end

   // Lowest set bit: first the lowest non-zero byte, then the bit in it.
   always_comb begin
      byte_hit = 1'b0;
      byte_idx = '0;
      for (int b = BYTES - 1; b >= 0; b--) begin
         if (search_word[b*8 +: 8] != '0) begin
            byte_hit = 1'b1;
            byte_idx = BYTE_W'(b);
         end
      end
      sel_byte = search_word[byte_idx*8 +: 8];
      bit_idx  = '0;
      for (int i = 7; i >= 0; i--) begin
         if (sel_byte[i]) begin
            bit_idx = 3'(i);
         end
      end
   end

   // Format mask: bits from fmt_lo up to eff_total - 1 within this word.
   always_comb begin
      addr_ext = TOTAL_W'(fmt_addr);
      lo_word  = geom.fmt_lo >> BIT_W;
      hi_word  = geom.eff_total >> BIT_W;
      if (addr_ext < lo_word) begin
         low_mask = '0;
      end else if (addr_ext == lo_word) begin
         low_mask = '1 << geom.fmt_lo[BIT_W-1:0];
      end else begin
         low_mask = '1;
      end
      if (addr_ext < hi_word) begin
         high_mask = '1;
      end else if (addr_ext == hi_word) begin
         high_mask = ~('1 << geom.eff_total[BIT_W-1:0]);
      end else begin
         high_mask = '0;
      end
   end

   assign res.pop      = pop_sum;
   assign res.hit      = byte_hit;
   assign res.first    = BIT_W'({byte_idx, bit_idx});
   assign res.fmt_mask = low_mask & high_mask;

endmodule

### hw/rtl/bba_engine.sv
// ---------------------------------------------------------------------------
// Block bitmap allocator engine
// Bitmap memory, sequencer for the four operations and the response register.
// ---------------------------------------------------------------------------
module bba_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  bba_pkg::bba_geom_type geom,
   bba_req_if.sink               req_chan,
   bba_rsp_if.source             rsp_chan
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] mem_rdata_ff;
   logic                 mem_we;
   logic                 mem_re;
   logic [WADDR_W-1:0]   mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;

   bba_state_type        state_ff, state_in;
   logic [SPAN_W-1:0]    ptr_ff, ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [WADDR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [BLOCK_W-1:0]   res_block_ff, res_block_in;
   logic [COUNT_W-1:0]   acc_ff, acc_in;
   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [BLOCK_W-1:0]   out_block_ff, out_block_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;

   bba_word_res_type     wres;
   logic [WADDR_W-1:0]   ptr_addr;
   logic [WORD_BITS-1:0] one_hot_first;
   logic [WORD_BITS-1:0] one_hot_blk;

   assign ptr_addr      = ptr_ff[WADDR_W-1:0];
   assign one_hot_first = WORD_BITS'(1) << wres.first;
   assign one_hot_blk   = WORD_BITS'(1) << blk_ff[BIT_W-1:0];

   bba_word_unit u_word (
      .scan_word (mem_rdata_ff),
      .scan_addr (rd_addr_ff),
      .fmt_addr  (ptr_addr),
      .geom      (geom),
      .res       (wres)
   );

   // Single-port bitmap memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         mem_rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      blk_ff        <= blk_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      acc_ff        <= acc_in;
      out_status_ff <= out_status_in;
      out_block_ff  <= out_block_in;
      out_count_ff  <= out_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      rd_vld_in     = 1'b0;
      rd_addr_in    = rd_addr_ff;
      blk_in        = blk_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      acc_in        = acc_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_block_in  = out_block_ff;
      out_count_in  = out_count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = ptr_addr;
      mem_wdata     = '0;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == SPAN_W'(MAP_WORDS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + SPAN_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_chan.valid) begin
               blk_in        = req_chan.block_number;
               res_status_in = STATUS_OK;
               res_block_in  = '0;
               acc_in        = '0;
               ptr_in        = '0;
               unique case (req_chan.func)
                  FUNC_ALLOC:  state_in = ST_ALLOC;
                  FUNC_FREE:   state_in = ST_FREE_RD;
                  FUNC_COUNT:  state_in = ST_COUNT;
                  FUNC_FORMAT: begin
                     if (geom.too_small) begin
                        res_status_in = STATUS_TOO_SMALL;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_FORMAT;
                     end
                  end
                  default:     state_in = ST_IDLE;
               endcase
            end
         end

         ST_ALLOC: begin
            if (rd_vld_ff && wres.hit) begin
               mem_we       = 1'b1;
               mem_addr     = rd_addr_ff;
               mem_wdata    = mem_rdata_ff & ~one_hot_first;
               res_block_in = BLOCK_W'({rd_addr_ff, wres.first});
               state_in     = ST_DONE;
            end else if (ptr_ff < geom.span_words) begin
               mem_re     = 1'b1;
               rd_vld_in  = 1'b1;
               rd_addr_in = ptr_addr;
               ptr_in     = ptr_ff + SPAN_W'(1);
            end else begin
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end
         end

         ST_COUNT: begin
            if (rd_vld_ff) begin
               acc_in = acc_ff + COUNT_W'(wres.pop);
            end
            if (ptr_ff < geom.span_words) begin
               mem_re     = 1'b1;
               rd_vld_in  = 1'b1;
               rd_addr_in = ptr_addr;
               ptr_in     = ptr_ff + SPAN_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_FREE_RD: begin
            if (TOTAL_W'(blk_ff) < geom.eff_total) begin
               mem_re   = 1'b1;
               mem_addr = WADDR_W'(blk_ff >> BIT_W);
               state_in = ST_FREE_WR;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_FREE_WR: begin
            mem_we    = 1'b1;
            mem_addr  = WADDR_W'(blk_ff >> BIT_W);
            mem_wdata = mem_rdata_ff | one_hot_blk;
            state_in  = ST_DONE;
         end

         ST_FORMAT: begin
            mem_we    = 1'b1;
            mem_wdata = wres.fmt_mask;
            if (ptr_ff == SPAN_W'(MAP_WORDS - 1)) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + SPAN_W'(1);
            end
         end

         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_block_in  = res_block_ff;
               out_count_in  = acc_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_status_ff;
   assign rsp_chan.allocated_block = out_block_ff;
   assign rsp_chan.free_count      = out_count_ff;

endmodule
